// ===== design/hcvg_pkg.sv =====
// Shared types, constants and rule tables for the Hilbert curve vertex generator.
// Used by hcvg_frame_stack and hilbert_curve_vertex_generator_core; no dependencies.
`timescale 1ns / 1ps

package hcvg_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int ORDER_W    = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ORDERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LOG2  = 1'b1;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] NUM_ORDERS_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] SIDE_LOG2_RST  = 4'd9;

    // A frame has made all three of its moves once its phase reaches this value.
    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef logic [1:0] phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BEGIN,
        ST_DESCEND,
        ST_POP,
        ST_OUTPUT
    } state_t;

    typedef enum logic [1:0] {
        RULE_A,
        RULE_B,
        RULE_C,
        RULE_D
    } rule_t;

    typedef enum logic [1:0] {
        DIR_W,
        DIR_E,
        DIR_N,
        DIR_S
    } dir_t;

    // What the vertex in flight is: the start of an order, a move, or nothing left.
    typedef enum logic [1:0] {
        KIND_START,
        KIND_MOVE,
        KIND_NONE
    } kind_t;

    // Commands from the sequencer to the frame stack.
    typedef struct packed {
        logic clear;
        logic start;
        logic push;
        logic step;
        logic pop;
    } stk_cmd_t;

    // Top-of-stack view returned to the sequencer.
    typedef struct packed {
        rule_t  top_rule;
        phase_t top_phase;
        logic   all_done;
    } stk_status_t;

    // Rule of the sub-curve that is expanded before move number phase of a rule.
    function automatic rule_t sub_rule(input rule_t rule, input phase_t phase);
        rule_t res;
        res = RULE_A;
        case (rule)
            RULE_A: begin
                case (phase)
                    2'd0:    res = RULE_D;
                    2'd3:    res = RULE_B;
                    default: res = RULE_A;
                endcase
            end
            RULE_B: begin
                case (phase)
                    2'd0:    res = RULE_C;
                    2'd3:    res = RULE_A;
                    default: res = RULE_B;
                endcase
            end
            RULE_C: begin
                case (phase)
                    2'd0:    res = RULE_B;
                    2'd3:    res = RULE_D;
                    default: res = RULE_C;
                endcase
            end
            RULE_D: begin
                case (phase)
                    2'd0:    res = RULE_A;
                    2'd3:    res = RULE_C;
                    default: res = RULE_D;
                endcase
            end
            default: res = RULE_A;
        endcase
        return res;
    endfunction

    // Direction of move number phase (0 to 2) of a rule.
    function automatic dir_t move_dir(input rule_t rule, input phase_t phase);
        dir_t res;
        res = DIR_W;
        case (rule)
            RULE_A: begin
                case (phase)
                    2'd0:    res = DIR_W;
                    2'd1:    res = DIR_N;
                    default: res = DIR_E;
                endcase
            end
            RULE_B: begin
                case (phase)
                    2'd0:    res = DIR_S;
                    2'd1:    res = DIR_E;
                    default: res = DIR_N;
                endcase
            end
            RULE_C: begin
                case (phase)
                    2'd0:    res = DIR_E;
                    2'd1:    res = DIR_S;
                    default: res = DIR_W;
                endcase
            end
            RULE_D: begin
                case (phase)
                    2'd0:    res = DIR_N;
                    2'd1:    res = DIR_W;
                    default: res = DIR_S;
                endcase
            end
            default: res = DIR_W;
        endcase
        return res;
    endfunction

endpackage

// ===== design/hcvg_frame_stack.sv =====
// Recursion frame stack of the Hilbert curve walker: rule and move count per level.
// Depends on hcvg_pkg for the rule table, command and status types.
`timescale 1ns / 1ps

module hcvg_frame_stack #(
    parameter int MAX_ORDER = 8,
    localparam int DEPTH_W  = $clog2(MAX_ORDER + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hcvg_pkg::stk_cmd_t      cmd,
    output logic [DEPTH_W-1:0]      depth,
    output hcvg_pkg::stk_status_t   status
);
    import hcvg_pkg::*;

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    rule_t              rule_reg  [MAX_ORDER];
    phase_t             phase_reg [MAX_ORDER];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [DEPTH_W-1:0] top_ptr;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;
    logic [MAX_ORDER-1:0] done_vec;

    // The open frame sits one below the depth count; a push lands at the count.
    assign top_ptr  = depth_reg - DEPTH_W'(1);
    assign top_idx  = top_ptr[IDX_W-1:0];
    assign push_idx = depth_reg[IDX_W-1:0];

    // Depth count update.
    always_comb begin
        depth_next = depth_reg;
        if (cmd.clear) begin
            depth_next = '0;
        end else if (cmd.start) begin
            depth_next = DEPTH_W'(1);
        end else if (cmd.push) begin
            depth_next = depth_reg + DEPTH_W'(1);
        end else if (cmd.pop) begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Frame contents; a level is only read below the depth count, so no reset.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rule_reg[0]  <= RULE_A;
            phase_reg[0] <= '0;
        end
        if (cmd.push) begin
            rule_reg[push_idx]  <= sub_rule(rule_reg[top_idx], phase_reg[top_idx]);
            phase_reg[push_idx] <= '0;
        end
        if (cmd.step) begin
            phase_reg[top_idx] <= phase_reg[top_idx] + 2'd1;
        end
    end

    // Every open level has made all of its moves.
    always_comb begin
        for (int i = 0; i < MAX_ORDER; i++) begin
            done_vec[i] = (phase_reg[i] == PHASE_LAST) || (DEPTH_W'(i) >= depth_reg);
        end
    end

    assign depth            = depth_reg;
    assign status.top_rule  = rule_reg[top_idx];
    assign status.top_phase = phase_reg[top_idx];
    assign status.all_done  = &done_vec;

endmodule

// ===== design/hilbert_curve_vertex_generator_core.sv =====
// Hilbert curve vertex generator core: one vertex of the superimposed curves per transfer.
// The vertex for an input transfer is set by the frame stack walk, which pops or
// pushes one recursion level per cycle around one move, and is registered to m_tvalid.
// Throughput: one item at a time; s_tready returns with m_tvalid; m_tready stalls add cycles.
// Reset: synchronous active-low aresetn restores the register defaults and the first vertex.
// Depends on hcvg_pkg and hcvg_frame_stack.
`timescale 1ns / 1ps

module hilbert_curve_vertex_generator_core #(
    parameter int MAX_ORDER  = 8,
    parameter int COORD_BITS = 12,
    localparam int M_TDATA_W = ((2 * COORD_BITS + hcvg_pkg::ORDER_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [hcvg_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] restart, rest zero
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,   // x, y, order from bit 0 up
    output logic [hcvg_pkg::M_TUSER_W-1:0]   m_tuser,   // curve_start, done_res
    output logic                             m_tlast,   // last
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hcvg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hcvg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hcvg_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_ORDER + 1);
    localparam int SHIFT_W = $clog2(COORD_BITS);

    state_t                 state_reg, state_next;
    logic [CFG_DATA_W-1:0]  num_orders_reg, num_orders_next;
    logic [CFG_DATA_W-1:0]  side_log2_reg, side_log2_next;
    logic [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]  origin_reg, origin_next;
    logic [COORD_BITS-1:0]  step_reg, step_next;
    logic [ORDER_W-1:0]     cur_order_reg, cur_order_next;
    logic                   finished_reg, finished_next;
    kind_t                  kind_reg, kind_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COORD_BITS-1:0]  out_x_reg, out_x_next;
    logic [COORD_BITS-1:0]  out_y_reg, out_y_next;
    logic [ORDER_W-1:0]     out_order_reg, out_order_next;
    logic                   out_start_reg, out_start_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_done_reg, out_done_next;

    stk_cmd_t               stk_cmd;
    stk_status_t            stk_status;
    logic [DEPTH_W-1:0]     stk_depth;

    logic [SHIFT_W-1:0]     shamt;
    logic [COORD_BITS-1:0]  half_side;
    logic                   first_order;
    logic [COORD_BITS-1:0]  step_begin;
    logic [COORD_BITS-1:0]  origin_base;
    logic [ORDER_W-1:0]     eff_orders;
    logic                   more_orders;
    dir_t                   mv_dir;
    logic                   mv_on_x;
    logic [COORD_BITS-1:0]  add_a;
    logic [COORD_BITS-1:0]  add_b;
    logic                   add_sub;
    logic [COORD_BITS-1:0]  add_sum;
    logic                   can_push;

    hcvg_frame_stack #(
        .MAX_ORDER (MAX_ORDER)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .depth   (stk_depth),
        .status  (stk_status)
    );

    // Half the square side, with the side exponent clamped to the coordinate range.
    always_comb begin
        if (side_log2_reg == '0) begin
            shamt = '0;
        end else if ({1'b0, side_log2_reg} > 5'(COORD_BITS)) begin
            shamt = SHIFT_W'(COORD_BITS - 1);
        end else begin
            shamt = SHIFT_W'(side_log2_reg - 4'd1);
        end
    end
    assign half_side = COORD_BITS'(1) << shamt;

    // Order count clamped to one through MAX_ORDER.
    always_comb begin
        if (num_orders_reg == '0) begin
            eff_orders = ORDER_W'(1);
        end else if (num_orders_reg > ORDER_W'(MAX_ORDER)) begin
            eff_orders = ORDER_W'(MAX_ORDER);
        end else begin
            eff_orders = num_orders_reg;
        end
    end

    // A further order is drawn only while its step would stay at least one pixel.
    assign more_orders = (cur_order_reg < eff_orders) && (|step_reg[COORD_BITS-1:1]);

    // Step and start point of the next order; the first order starts from half the side.
    assign first_order = (cur_order_reg == '0);
    assign step_begin  = first_order ? half_side : (step_reg >> 1);
    assign origin_base = first_order ? half_side : origin_reg;

    // Move of the open frame.
    assign mv_dir  = move_dir(stk_status.top_rule, stk_status.top_phase);
    assign mv_on_x = (mv_dir == DIR_W) || (mv_dir == DIR_E);

    // The one shared add/subtract unit: coordinate moves and start point offsets.
    always_comb begin
        if (state_reg == ST_POP) begin
            add_a   = mv_on_x ? cur_x_reg : cur_y_reg;
            add_b   = step_reg;
            add_sub = (mv_dir == DIR_W) || (mv_dir == DIR_N);
        end else begin
            add_a   = origin_base;
            add_b   = step_begin >> 1;
            add_sub = 1'b0;
        end
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    assign can_push = (ORDER_W'(stk_depth) < cur_order_reg) &&
                      (stk_depth < DEPTH_W'(MAX_ORDER));

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        num_orders_next = num_orders_reg;
        side_log2_next  = side_log2_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_NUM_ORDERS: num_orders_next = cfg_data;
                REG_SIDE_LOG2:  side_log2_next  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: next state, stack commands and the result register.
    always_comb begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        origin_next    = origin_reg;
        step_next      = step_reg;
        cur_order_next = cur_order_reg;
        finished_next  = finished_reg;
        kind_next      = kind_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_order_next = out_order_reg;
        out_start_next = out_start_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        stk_cmd        = '0;

        // The result register empties on a transfer.
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[0]) begin
                        cur_order_next = '0;
                        finished_next  = 1'b0;
                        stk_cmd.clear  = 1'b1;
                        state_next     = ST_BEGIN;
                    end else if (finished_reg) begin
                        kind_next  = KIND_NONE;
                        state_next = ST_OUTPUT;
                    end else if (first_order) begin
                        state_next = ST_BEGIN;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_BEGIN: begin
                step_next      = step_begin;
                origin_next    = add_sum;
                cur_x_next     = add_sum;
                cur_y_next     = add_sum;
                cur_order_next = cur_order_reg + ORDER_W'(1);
                stk_cmd.start  = 1'b1;
                kind_next      = KIND_START;
                state_next     = ST_DESCEND;
            end
            ST_DESCEND: begin
                if (can_push) begin
                    stk_cmd.push = 1'b1;
                end else begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_POP: begin
                if (stk_depth == '0) begin
                    if (more_orders) begin
                        state_next = ST_BEGIN;
                    end else begin
                        finished_next = 1'b1;
                        kind_next     = KIND_NONE;
                        state_next    = ST_OUTPUT;
                    end
                end else if (stk_status.top_phase != PHASE_LAST) begin
                    if (mv_on_x) begin
                        cur_x_next = add_sum;
                    end else begin
                        cur_y_next = add_sum;
                    end
                    stk_cmd.step = 1'b1;
                    kind_next    = KIND_MOVE;
                    state_next   = ST_DESCEND;
                end else begin
                    stk_cmd.pop = 1'b1;
                end
            end
            ST_OUTPUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_x_next     = cur_x_reg;
                    out_y_next     = cur_y_reg;
                    out_order_next = cur_order_reg;
                    out_start_next = (kind_reg == KIND_START);
                    out_done_next  = (kind_reg == KIND_NONE);
                    out_last_next  = (kind_reg != KIND_NONE) && stk_status.all_done &&
                                     !more_orders;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_orders_reg <= NUM_ORDERS_RST;
            side_log2_reg  <= SIDE_LOG2_RST;
            cur_order_reg  <= '0;
            finished_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_orders_reg <= num_orders_next;
            side_log2_reg  <= side_log2_next;
            cur_order_reg  <= cur_order_next;
            finished_reg   <= finished_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge aclk) begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        origin_reg    <= origin_next;
        step_reg      <= step_next;
        kind_reg      <= kind_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_order_reg <= out_order_next;
        out_start_reg <= out_start_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    // Port packing.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_done_reg, out_start_reg};

    always_comb begin
        m_tdata = '0;
        m_tdata[COORD_BITS-1:0]                           = out_x_reg;
        m_tdata[2*COORD_BITS-1:COORD_BITS]                = out_y_reg;
        m_tdata[2*COORD_BITS+ORDER_W-1:2*COORD_BITS]      = out_order_reg;
    end

`ifndef SYNTHESIS
    // The stack never holds more levels than the order being drawn.
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ORDER_W'(stk_depth) <= cur_order_reg)
        else $error("frame stack deeper than current order");

    // A start vertex leaves the sequencer exactly at the new order's start point.
    a_start_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUTPUT && kind_reg == KIND_START) |->
        (cur_x_reg == origin_reg && cur_y_reg == origin_reg))
        else $error("start vertex differs from order origin");

    // The stack walk only runs inside a live order.
    a_pop_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (cur_order_reg != '0 && !finished_reg))
        else $error("stack walk outside a live order");

    // Orders never run past the clamp.
    a_order_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_order_reg <= ORDER_W'(MAX_ORDER))
        else $error("current order above maximum");
`endif

endmodule
